// ===== src/bhpq_pkg.sv =====
// Shared types and constants for the max priority queue core.
`timescale 1ns / 1ps

package bhpq_pkg;

	// Fixed sizes of the queue and of its beats.
	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int COUNT_WIDTH = 7;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic [COUNT_WIDTH-1:0]        count_t;

	// Operation codes of a command beat.
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	// One command beat.
	typedef struct packed {
		op_t    op;
		value_t value;
	} cmd_beat_t;

	// One result beat.
	typedef struct packed {
		value_t removed_value;
		logic   was_empty;
		logic   overflow;
		count_t entry_count;
	} result_beat_t;

	// Per-cycle control broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic remove;
	} cell_ctrl_t;

endpackage

// ===== src/bhpq_cell.sv =====
// One storage cell of the sorted chain: holds one entry and trades with its neighbors.
`timescale 1ns / 1ps

module bhpq_cell
	import bhpq_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  value_t     new_value,
	input  logic       occupied,
	input  value_t     left_value,
	input  logic       left_goes_after,
	input  value_t     right_value,
	output value_t     value,
	output logic       goes_after
);

	value_t value_q;

	// The new value belongs in front of this entry when the cell is free or it is larger.
	assign goes_after = !occupied || (new_value > value_q);
	assign value      = value_q;

	// Insert shifts the tail one place right and drops the new value into the gap;
	// remove shifts the whole chain one place left.
	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (goes_after) begin
				value_q <= left_goes_after ? left_value : new_value;
			end
		end else if (ctrl.remove) begin
			value_q <= right_value;
		end
	end

endmodule

// ===== src/binary_max_heap_priority_queue_core.sv =====
// Top level of the max priority queue: a sorted chain of cells plus the command and result beats.
`timescale 1ns / 1ps

// The queue keeps up to 64 signed 32-bit entries in a row of cells that stays sorted,
// largest first. A command beat is taken in every clock cycle (busy stays low), and its
// result beat appears on result with done high in the next cycle. The result comes from
// the compare-and-shift step that every cell performs in parallel: an insert
// compares the new value against all cells at once and shifts the smaller entries one
// place, a remove shifts the whole row one place toward the head. Results cannot be held
// off, so the receiver must take each beat in the cycle that done is high. Inserting into
// a full queue drops the value and reports overflow; removing from an empty queue reports
// was_empty with a zero value.

module binary_max_heap_priority_queue_core
	import bhpq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  cmd_beat_t    cmd,
	output logic         done,
	output result_beat_t result
);

	count_t       fill_count_q;
	logic         done_q;
	result_beat_t result_q;

	logic         accept;
	logic         is_full;
	logic         is_empty;
	cell_ctrl_t   ctrl;
	count_t       fill_count_next;
	result_beat_t result_next;

	value_t       cell_value [CAPACITY];
	logic         cell_after [CAPACITY];

	// Every cycle completes one command, so the queue never pushes back.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Command decode against the current fill level.
	assign is_full     = (fill_count_q == COUNT_WIDTH'(CAPACITY));
	assign is_empty    = (fill_count_q == '0);
	assign ctrl.insert = accept && (cmd.op == OP_INSERT) && !is_full;
	assign ctrl.remove = accept && (cmd.op == OP_REMOVE) && !is_empty;

	// The chain of cells; the head cell holds the largest entry.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		value_t left_value;
		logic   left_after;
		value_t right_value;

		if (i == 0) begin : g_head
			assign left_value = cmd.value;
			assign left_after = 1'b0;
		end else begin : g_body
			assign left_value = cell_value[i-1];
			assign left_after = cell_after[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_value = cell_value[i];
		end else begin : g_inner
			assign right_value = cell_value[i+1];
		end

		bhpq_cell u_cell (
			.clk             (clk),
			.ctrl            (ctrl),
			.new_value       (cmd.value),
			.occupied        (fill_count_q > COUNT_WIDTH'(i)),
			.left_value      (left_value),
			.left_goes_after (left_after),
			.right_value     (right_value),
			.value           (cell_value[i]),
			.goes_after      (cell_after[i])
		);
	end

	// Next fill level and the result beat for the accepted command.
	always_comb begin
		fill_count_next = fill_count_q;
		if (ctrl.insert) begin
			fill_count_next = fill_count_q + COUNT_WIDTH'(1);
		end else if (ctrl.remove) begin
			fill_count_next = fill_count_q - COUNT_WIDTH'(1);
		end

		result_next.removed_value = ctrl.remove ? cell_value[0] : '0;
		result_next.was_empty     = (cmd.op == OP_REMOVE) && is_empty;
		result_next.overflow      = (cmd.op == OP_INSERT) && is_full;
		result_next.entry_count   = fill_count_next;
	end

	// Fill level and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q <= '0;
			done_q       <= 1'b0;
		end else begin
			fill_count_q <= fill_count_next;
			done_q       <= accept;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_next;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Every accepted command yields a result beat in the next cycle.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("result beat missing after accepted command");

	// The fill level never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q <= COUNT_WIDTH'(CAPACITY))
		else $error("fill count beyond capacity");

	// An overflow is only reported with the queue full.
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.overflow |-> result.entry_count == COUNT_WIDTH'(CAPACITY))
		else $error("overflow reported on a queue that is not full");

	// An empty remove reports a zero value and an empty queue.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.was_empty |-> result.removed_value == '0 && result.entry_count == '0)
		else $error("empty remove reported a value or entries");

	// The head of the chain is never smaller than the entry behind it.
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q >= COUNT_WIDTH'(2) |-> cell_value[0] >= cell_value[1])
		else $error("chain head is not the largest entry");

endmodule

// ===== tb/binary_max_heap_priority_queue_core_tb.sv =====
// Self-checking testbench for the max priority queue core: directed and random command beats.
`timescale 1ns / 1ps

module binary_max_heap_priority_queue_core_tb
	import bhpq_pkg::*;
;

	// Tracks the queue contents as a binary max heap and checks every result beat in order.
	class max_queue_tracker;
		value_t       slots[CAPACITY];
		int           used;
		result_beat_t pending_results[$];
		int           mismatch_count;

		function new();
			used = 0;
			mismatch_count = 0;
		endfunction

		function void swap_slots(int a, int b);
			value_t t;
			t = slots[a];
			slots[a] = slots[b];
			slots[b] = t;
		endfunction

		// Applies one accepted command beat to the heap and queues the result it must produce.
		function void note_command(cmd_beat_t c);
			result_beat_t r;
			int pos;
			int kid;
			r = '0;
			if (c.op == OP_INSERT) begin
				if (used >= CAPACITY) begin
					r.overflow = 1'b1;
				end else begin
					// Append and sift up while strictly larger than the parent.
					slots[used] = c.value;
					pos = used;
					used++;
					while (pos > 0 && slots[pos] > slots[(pos - 1) / 2]) begin
						swap_slots(pos, (pos - 1) / 2);
						pos = (pos - 1) / 2;
					end
				end
			end else if (used == 0) begin
				r.was_empty = 1'b1;
			end else begin
				r.removed_value = slots[0];
				used--;
				if (used > 0) begin
					// Move the last entry to the root and sift it down; ties favor the left child.
					slots[0] = slots[used];
					pos = 0;
					while (2 * pos + 1 < used) begin
						kid = 2 * pos + 1;
						if (kid + 1 < used && slots[kid + 1] > slots[kid])
							kid++;
						if (!(slots[kid] > slots[pos]))
							break;
						swap_slots(pos, kid);
						pos = kid;
					end
				end
			end
			r.entry_count = count_t'(used);
			pending_results.insert(pending_results.size(), r);
		endfunction

		// Compares one result beat field by field with the oldest pending one.
		function void check_result(result_beat_t got);
			result_beat_t want;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result beat with none pending, actual %p", $time, got);
				return;
			end
			want = pending_results.pop_front();
			if (got.removed_value !== want.removed_value) begin
				mismatch_count++;
				$display("%0t: removed_value expected %0d actual %0d", $time,
					want.removed_value, got.removed_value);
			end
			if (got.was_empty !== want.was_empty) begin
				mismatch_count++;
				$display("%0t: was_empty expected %b actual %b", $time, want.was_empty,
					got.was_empty);
			end
			if (got.overflow !== want.overflow) begin
				mismatch_count++;
				$display("%0t: overflow expected %b actual %b", $time, want.overflow,
					got.overflow);
			end
			if (got.entry_count !== want.entry_count) begin
				mismatch_count++;
				$display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
					got.entry_count);
			end
		endfunction
	endclass

	localparam int     RESET_CYCLES = 12;
	localparam int     RANDOM_ITEMS = 1250;
	localparam int     STALL_LIMIT  = 2000;
	localparam int     DRAIN_CYCLES = 10;
	localparam value_t VALUE_MIN    = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
	localparam value_t VALUE_MAX    = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         start = 1'b0;
	cmd_beat_t    cmd = '0;
	logic         busy;
	logic         done;
	result_beat_t result;

	max_queue_tracker tracker;
	logic             idle_enable = 1'b1;
	int               stall_cycles = 0;
	int               sent = 0;

	binary_max_heap_priority_queue_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Every result beat is taken in the cycle that done is high.
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_result(result);
	end

	// Ends the run when no beat moves in either direction for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Mostly wide random values, with clusters of small ones for ties and the extremes.
	function automatic value_t pick_value();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: return VALUE_MIN;
					1: return VALUE_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2: return value_t'(int'($urandom_range(16)) - 8);
			default: return value_t'($urandom);
		endcase
	endfunction

	// Drives one command beat from a falling edge and holds it until it is accepted.
	task automatic send_command(input op_t op, input value_t value);
		cmd_beat_t c;
		c.op = op;
		c.value = value;
		while (idle_enable && $urandom_range(99) < 24) begin
			start = 1'b0;
			cmd = cmd_beat_t'({1'($urandom), 32'($urandom)});
			@(negedge clk);
		end
		start = 1'b1;
		cmd = c;
		do
			@(posedge clk);
		while (busy);
		tracker.note_command(c);
		@(negedge clk);
	endtask

	initial begin
		op_t op;
		int  mode;
		int  span;

		tracker = new();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// An empty remove, with a nonzero value that must be ignored.
		send_command(OP_REMOVE, value_t'(32'hDEADBEEF));
		// Extremes and equal values, then drain past empty.
		send_command(OP_INSERT, VALUE_MAX);
		send_command(OP_INSERT, VALUE_MIN);
		send_command(OP_INSERT, '0);
		send_command(OP_INSERT, '1);
		send_command(OP_INSERT, value_t'(5));
		send_command(OP_INSERT, value_t'(5));
		send_command(OP_INSERT, VALUE_MIN);
		repeat (8) send_command(OP_REMOVE, VALUE_MAX);
		// Equal children under the root during sift-down.
		send_command(OP_INSERT, value_t'(10));
		send_command(OP_INSERT, value_t'(6));
		send_command(OP_INSERT, value_t'(6));
		send_command(OP_INSERT, value_t'(1));
		repeat (5) send_command(OP_REMOVE, '0);

		// Random phases that fill past capacity, drain to empty, or hover in between.
		while (sent < RANDOM_ITEMS) begin
			mode = $urandom_range(2);
			span = $urandom_range(40, 140);
			repeat (span) begin
				idle_enable = !(sent >= 500 && sent < 750);
				case (mode)
					0: op = ($urandom_range(99) < 85) ? OP_INSERT : OP_REMOVE;
					1: op = ($urandom_range(99) < 15) ? OP_INSERT : OP_REMOVE;
					default: op = ($urandom_range(1) == 0) ? OP_INSERT : OP_REMOVE;
				endcase
				send_command(op, pick_value());
				sent++;
			end
		end
		start = 1'b0;

		// Wait for the last result beats, then a few more cycles for strays.
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
src/bhpq_pkg.sv
src/bhpq_cell.sv
src/binary_max_heap_priority_queue_core.sv
tb/binary_max_heap_priority_queue_core_tb.sv
